// ----- rtl/core/ptpd_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptpd_pkg: shared types and constants of the pan/tilt PD tracker
// Fixed-point formats, field widths, register indexes and beat structs.
// ----------------------------------------------------------------------------
package ptpd_pkg;

    // fixed-point formats
    localparam int FRAC_BITS   = 12;
    localparam int ANGLE_LIMIT = 180;
    localparam int ANGLE_START = 90;

    // field widths
    localparam int POS_W   = 10;               // pixel coordinates
    localparam int GAIN_W  = 16;               // unsigned gains
    localparam int DZ_W    = 8;                // dead zone threshold
    localparam int DEG_W   = 8;                // integer degrees
    localparam int ERR_W   = POS_W + 1;        // signed pixel error
    localparam int DER_W   = POS_W + 2;        // signed error difference
    localparam int PROD_W  = GAIN_W + DER_W;   // signed gain product
    localparam int SUM_W   = PROD_W + 1;       // signed drive
    localparam int ANGLE_W = DEG_W + FRAC_BITS;
    localparam int ACC_W   = SUM_W + 2;        // angle update before clamp

    localparam logic [ANGLE_W-1:0] ANGLE_TOP   = ANGLE_W'(ANGLE_LIMIT) << FRAC_BITS;
    localparam logic [ANGLE_W-1:0] ANGLE_RESET = ANGLE_W'(ANGLE_START) << FRAC_BITS;
    localparam logic signed [ACC_W-1:0] ACC_TOP = ACC_W'($signed({1'b0, ANGLE_TOP}));

    // configuration port
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = GAIN_W;

    localparam logic [CFG_ADDR_W-1:0] REG_PAN_GAIN_P  = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_PAN_GAIN_D  = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_TILT_GAIN_P = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_TILT_GAIN_D = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_CENTER_X    = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_CENTER_Y    = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] REG_DEADBAND    = 3'd6;

    // register reset values
    localparam logic [GAIN_W-1:0] GAIN_P_RESET    = 16'd287;
    localparam logic [GAIN_W-1:0] GAIN_D_RESET    = 16'd410;
    localparam logic [POS_W-1:0]  CENTER_X_RESET  = 10'd160;
    localparam logic [POS_W-1:0]  CENTER_Y_RESET  = 10'd120;
    localparam logic [DZ_W-1:0]   DEADBAND_RESET  = 8'd3;

    typedef struct packed {
        logic [POS_W-1:0] target_x;
        logic [POS_W-1:0] target_y;
    } ptpd_in_t;

    typedef struct packed {
        logic [DEG_W-1:0] pan_degrees;
        logic [DEG_W-1:0] tilt_degrees;
    } ptpd_out_t;

    // stage advance strobes from the pipeline control
    typedef struct packed {
        logic s1;   // input register to error stage
        logic s2;   // error stage to product stage
        logic s3;   // product stage to angle/result stage
    } ptpd_adv_t;

endpackage

// ----- rtl/core/ptpd_axis.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptpd_axis: datapath of one tracker axis
// Dead-zoned error, PD products and clamped angle update in three stages.
// ----------------------------------------------------------------------------
module ptpd_axis
    import ptpd_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  ptpd_adv_t         adv,
    input  logic [POS_W-1:0]  target,
    input  logic [POS_W-1:0]  center,
    input  logic [DZ_W-1:0]   deadband,
    input  logic [GAIN_W-1:0] gain_p,
    input  logic [GAIN_W-1:0] gain_d,
    input  logic              invert,
    output logic [DEG_W-1:0]  degrees
);

    logic signed [ERR_W-1:0]  diff;
    logic        [POS_W-1:0]  mag;
    logic signed [ERR_W-1:0]  zoned;
    logic signed [DER_W-1:0]  deriv;
    logic signed [ERR_W-1:0]  err_reg;    // also the previous error
    logic signed [DER_W-1:0]  der_reg;
    logic signed [PROD_W-1:0] prod_p_reg;
    logic signed [PROD_W-1:0] prod_d_reg;
    logic signed [SUM_W-1:0]  drive;
    logic signed [ACC_W-1:0]  acc;
    logic        [ANGLE_W-1:0] angle_next;
    logic        [ANGLE_W-1:0] angle_reg;

    // error against centre, zeroed inside the dead zone
    assign diff  = $signed({1'b0, target}) - $signed({1'b0, center});
    assign mag   = diff[ERR_W-1] ? POS_W'(-diff) : POS_W'(diff);
    assign zoned = (mag < POS_W'(deadband)) ? '0 : diff;
    assign deriv = DER_W'(zoned) - DER_W'(err_reg);

    // hold the error as history for the next beat
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            err_reg <= '0;
        end else if (adv.s1) begin
            err_reg <= zoned;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv.s1) begin
            der_reg <= deriv;
        end
    end

    // gain products
    always_ff @(posedge aclk) begin
        if (adv.s2) begin
            prod_p_reg <= PROD_W'($signed({1'b0, gain_p})) * PROD_W'(err_reg);
            prod_d_reg <= PROD_W'($signed({1'b0, gain_d})) * PROD_W'(der_reg);
        end
    end

    // apply the drive and clamp to the travel range
    assign drive = SUM_W'(prod_p_reg) + SUM_W'(prod_d_reg);
    assign acc   = ACC_W'($signed({1'b0, angle_reg}))
                 + (invert ? -ACC_W'(drive) : ACC_W'(drive));

    always_comb begin
        if (acc[ACC_W-1]) begin
            angle_next = '0;
        end else if (acc > ACC_TOP) begin
            angle_next = ANGLE_TOP;
        end else begin
            angle_next = acc[ANGLE_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            angle_reg <= ANGLE_RESET;
        end else if (adv.s3) begin
            angle_reg <= angle_next;
        end
    end

    assign degrees = angle_reg[ANGLE_W-1:FRAC_BITS];

endmodule

// ----- rtl/core/pan_tilt_pd_tracker_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pan_tilt_pd_tracker_core: two-axis PD tracker with dead zone
// Turns target points into pan and tilt servo angles in whole degrees.
// ----------------------------------------------------------------------------
// Usage:
//   s_valid/s_ready/s_data carries one target point (x, y) per beat.
//   m_valid/m_ready/m_data carries one pair of angles per input beat,
//   in the same order.
//   cfg_wr_en/cfg_addr/cfg_wr_data writes a gain, centre or dead zone
//   register; write only while no beat is in flight.
//   Throughput: one beat per cycle while m_ready stays high. A beat
//   passes the input register, error stage, product stage and
//   angle/result register in that order; m_valid shows the last. The
//   angle recurrence closes in the last stage: a single add of the PD
//   drive and a clamp to 0..180.
//   A stalled receiver holds its result; upstream stages keep accepting
//   beats until every stage is full, then s_ready drops.
//   Reset (aresetn low, synchronous) empties the pipeline, sets both
//   angles to 90 degrees, the previous errors to zero and all registers
//   to their defaults.
// ----------------------------------------------------------------------------
module pan_tilt_pd_tracker_core
    import ptpd_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  ptpd_in_t              s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output ptpd_out_t             m_data,
    input  logic                  cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wr_data
);

    logic [GAIN_W-1:0] pan_gain_p_reg;
    logic [GAIN_W-1:0] pan_gain_d_reg;
    logic [GAIN_W-1:0] tilt_gain_p_reg;
    logic [GAIN_W-1:0] tilt_gain_d_reg;
    logic [POS_W-1:0]  center_x_reg;
    logic [POS_W-1:0]  center_y_reg;
    logic [DZ_W-1:0]   deadband_reg;

    ptpd_in_t  in_reg;
    logic      v0_reg, v1_reg, v2_reg, v3_reg;
    logic      rdy1, rdy2, rdy3;
    ptpd_adv_t adv;
    logic [DEG_W-1:0] pan_deg, tilt_deg;

    // register writes; unknown indexes are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pan_gain_p_reg  <= GAIN_P_RESET;
            pan_gain_d_reg  <= GAIN_D_RESET;
            tilt_gain_p_reg <= GAIN_P_RESET;
            tilt_gain_d_reg <= GAIN_D_RESET;
            center_x_reg    <= CENTER_X_RESET;
            center_y_reg    <= CENTER_Y_RESET;
            deadband_reg    <= DEADBAND_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                REG_PAN_GAIN_P:  pan_gain_p_reg  <= cfg_wr_data;
                REG_PAN_GAIN_D:  pan_gain_d_reg  <= cfg_wr_data;
                REG_TILT_GAIN_P: tilt_gain_p_reg <= cfg_wr_data;
                REG_TILT_GAIN_D: tilt_gain_d_reg <= cfg_wr_data;
                REG_CENTER_X:    center_x_reg    <= cfg_wr_data[POS_W-1:0];
                REG_CENTER_Y:    center_y_reg    <= cfg_wr_data[POS_W-1:0];
                REG_DEADBAND:    deadband_reg    <= cfg_wr_data[DZ_W-1:0];
                default: ;
            endcase
        end
    end

    // stage ready chain: a stage takes a beat when empty or draining
    assign rdy3    = !v3_reg || m_ready;
    assign rdy2    = !v2_reg || rdy3;
    assign rdy1    = !v1_reg || rdy2;
    assign s_ready = !v0_reg || rdy1;

    assign adv.s1 = v0_reg && rdy1;
    assign adv.s2 = v1_reg && rdy2;
    assign adv.s3 = v2_reg && rdy3;

    // stage valid flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                v0_reg <= 1'b1;
            end else if (adv.s1) begin
                v0_reg <= 1'b0;
            end
            if (adv.s1) begin
                v1_reg <= 1'b1;
            end else if (adv.s2) begin
                v1_reg <= 1'b0;
            end
            if (adv.s2) begin
                v2_reg <= 1'b1;
            end else if (adv.s3) begin
                v2_reg <= 1'b0;
            end
            if (adv.s3) begin
                v3_reg <= 1'b1;
            end else if (m_ready) begin
                v3_reg <= 1'b0;
            end
        end
    end

    // capture the input beat
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_reg <= s_data;
        end
    end

    // pan moves against its drive, tilt with it
    ptpd_axis u_pan (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .target    (in_reg.target_x),
        .center    (center_x_reg),
        .deadband  (deadband_reg),
        .gain_p    (pan_gain_p_reg),
        .gain_d    (pan_gain_d_reg),
        .invert    (1'b1),
        .degrees   (pan_deg)
    );

    ptpd_axis u_tilt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .target    (in_reg.target_y),
        .center    (center_y_reg),
        .deadband  (deadband_reg),
        .gain_p    (tilt_gain_p_reg),
        .gain_d    (tilt_gain_d_reg),
        .invert    (1'b0),
        .degrees   (tilt_deg)
    );

    assign m_valid             = v3_reg;
    assign m_data.pan_degrees  = pan_deg;
    assign m_data.tilt_degrees = tilt_deg;

`ifndef SYNTHESIS
    // results never leave the travel range
    a_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.pan_degrees <= DEG_W'(ANGLE_LIMIT))
                 && (m_data.tilt_degrees <= DEG_W'(ANGLE_LIMIT)))
        else $error("angle beyond limit");

    // a beat into an empty pipeline must show on m_valid
    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && !v1_reg && !v2_reg && !v3_reg) |-> ##4 m_valid)
        else $error("beat lost in pipeline");

    // the result only changes when a beat enters the last stage
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (!v2_reg && $past(aresetn)) |=> $stable(m_data))
        else $error("result changed without a beat");
`endif

endmodule
